FILE: rtl/tms_pkg.sv
package tms_pkg;

  // Input operation codes
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_BEGIN  = 2'd1;
  localparam logic [1:0] OP_EVENT  = 2'd2;

  // Result action codes
  localparam logic [2:0] ACT_SEND       = 3'd0;
  localparam logic [2:0] ACT_START      = 3'd1;
  localparam logic [2:0] ACT_START_STOP = 3'd2;
  localparam logic [2:0] ACT_STOP       = 3'd3;
  localparam logic [2:0] ACT_RECV       = 3'd4;
  localparam logic [2:0] ACT_DONE       = 3'd5;

  // Done status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_ADDR_NACK = 2'd1;
  localparam logic [1:0] ST_DATA_NACK = 2'd2;
  localparam logic [1:0] ST_BAD_REQ   = 2'd3;

  // Transaction phase codes
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_WRITE = 2'd1;
  localparam logic [1:0] PH_READ  = 2'd2;

  // Event enable bit positions
  localparam int unsigned EN_NACK   = 0;
  localparam int unsigned EN_RXRDY  = 1;
  localparam int unsigned EN_TXRDY  = 2;
  localparam int unsigned EN_TXCOMP = 3;

  // One queued command: one or two results that share the payload fields.
  typedef struct packed {
    logic [2:0]  act0;
    logic [2:0]  act1;
    logic        two;
    logic [7:0]  data;
    logic [6:0]  target;
    logic        dir;
    logic [23:0] raddr;
    logic [1:0]  rlen;
    logic [1:0]  status;
    logic [15:0] count;
  } cmd_t;

endpackage

FILE: rtl/tms_front.sv
module tms_front #(
  parameter int unsigned TX_DEPTH = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               q_full_i,
  input  logic [1:0]         op_i,
  input  logic [6:0]         slave_addr_i,
  input  logic [6:0]         tx_len_i,
  input  logic [15:0]        rx_len_i,
  input  logic [23:0]        internal_addr_i,
  input  logic [1:0]         internal_addr_len_i,
  input  logic [7:0]         data_byte_i,
  input  logic               ev_nack_i,
  input  logic               ev_rxrdy_i,
  input  logic               ev_txrdy_i,
  input  logic               ev_txcomp_i,
  output logic               push_o,
  output tms_pkg::cmd_t      cmd_o
);

  localparam int unsigned CNT_W = $clog2(TX_DEPTH + 1);
  localparam int unsigned IDX_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
  localparam int unsigned CMP_W = (CNT_W > 7) ? CNT_W : 7;

  logic [1:0]       phase_q, phase_d;
  logic [CNT_W-1:0] fill_q, fill_d;
  logic [CNT_W-1:0] tx_count_q, tx_count_d;
  logic [CNT_W-1:0] tx_pos_q, tx_pos_d;
  logic [15:0]      rx_count_q, rx_count_d;
  logic [15:0]      rx_pos_q, rx_pos_d;
  logic [6:0]       slave_q, slave_d;
  logic [23:0]      raddr_q, raddr_d;
  logic [1:0]       rlen_q, rlen_d;
  logic [3:0]       en_q, en_d;

  logic [7:0]       mem [TX_DEPTH];
  logic [7:0]       rd_q;
  logic             mem_we;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;

  logic             accept;
  logic             has_cmd;
  tms_pkg::cmd_t    cmd;

  assign accept    = in_valid_i && !q_full_i;
  assign mem_waddr = fill_q[IDX_W-1:0];
  assign mem_raddr = tx_pos_d[IDX_W-1:0];

  always_comb begin
    logic [CMP_W-1:0] tl_ext;
    logic [CMP_W-1:0] avail_ext;
    logic [16:0]      rx_next;
    logic [CNT_W-1:0] pos_next;
    logic             sending;
    logic             data_nack;
    logic             nack, rxrdy, txrdy, txcomp;

    tl_ext    = CMP_W'(tx_len_i);
    avail_ext = CMP_W'(fill_q);
    rx_next   = {1'b0, rx_pos_q} + 17'd1;
    sending   = (tx_pos_q < tx_count_q) && (CMP_W'(tx_pos_q) < CMP_W'(TX_DEPTH));
    pos_next  = sending ? tx_pos_q + CNT_W'(1) : tx_pos_q;
    data_nack = (phase_q == tms_pkg::PH_WRITE) ? (tx_pos_q > CNT_W'(1))
                                               : (rx_pos_q != 16'd0);
    nack      = ev_nack_i && en_q[tms_pkg::EN_NACK];
    rxrdy     = ev_rxrdy_i && en_q[tms_pkg::EN_RXRDY];
    txrdy     = ev_txrdy_i && en_q[tms_pkg::EN_TXRDY];
    txcomp    = ev_txcomp_i && en_q[tms_pkg::EN_TXCOMP];

    phase_d    = phase_q;
    fill_d     = fill_q;
    tx_count_d = tx_count_q;
    tx_pos_d   = tx_pos_q;
    rx_count_d = rx_count_q;
    rx_pos_d   = rx_pos_q;
    slave_d    = slave_q;
    raddr_d    = raddr_q;
    rlen_d     = rlen_q;
    en_d       = en_q;
    mem_we     = 1'b0;
    has_cmd    = 1'b0;
    cmd        = '0;

    if (accept) begin
      unique case (op_i)
        tms_pkg::OP_APPEND: begin
          if (phase_q == tms_pkg::PH_IDLE && CMP_W'(fill_q) < CMP_W'(TX_DEPTH)) begin
            mem_we = 1'b1;
            fill_d = fill_q + CNT_W'(1);
          end
        end
        tms_pkg::OP_BEGIN: begin
          has_cmd = 1'b1;
          if (phase_q != tms_pkg::PH_IDLE) begin
            cmd.act0   = tms_pkg::ACT_DONE;
            cmd.status = tms_pkg::ST_BAD_REQ;
          end else begin
            fill_d = '0;
            if ((tx_len_i == 7'd0 && rx_len_i == 16'd0) || tl_ext > avail_ext) begin
              rx_pos_d   = '0;
              cmd.act0   = tms_pkg::ACT_DONE;
              cmd.status = tms_pkg::ST_BAD_REQ;
            end else begin
              slave_d    = slave_addr_i;
              rlen_d     = internal_addr_len_i;
              raddr_d    = (internal_addr_len_i != 2'd0) ? internal_addr_i : 24'd0;
              tx_count_d = tl_ext[CNT_W-1:0];
              rx_count_d = rx_len_i;
              rx_pos_d   = '0;
              cmd.target = slave_addr_i;
              cmd.raddr  = raddr_d;
              cmd.rlen   = internal_addr_len_i;
              if (tx_len_i != 7'd0) begin
                // Preload byte 0, then open the write phase
                phase_d  = tms_pkg::PH_WRITE;
                tx_pos_d = CNT_W'(1);
                cmd.two  = 1'b1;
                cmd.act0 = tms_pkg::ACT_SEND;
                cmd.data = rd_q;
                cmd.act1 = (tx_len_i == 7'd1) ? tms_pkg::ACT_START_STOP
                                              : tms_pkg::ACT_START;
                en_d     = 4'd0;
                en_d[tms_pkg::EN_NACK] = 1'b1;
                if (tx_len_i == 7'd1) en_d[tms_pkg::EN_TXCOMP] = 1'b1;
                else                  en_d[tms_pkg::EN_TXRDY]  = 1'b1;
              end else begin
                phase_d  = tms_pkg::PH_READ;
                tx_pos_d = '0;
                cmd.dir  = 1'b1;
                cmd.act0 = (rx_len_i == 16'd1) ? tms_pkg::ACT_START_STOP
                                               : tms_pkg::ACT_START;
                en_d     = 4'd0;
                en_d[tms_pkg::EN_NACK]  = 1'b1;
                en_d[tms_pkg::EN_RXRDY] = 1'b1;
              end
            end
          end
        end
        tms_pkg::OP_EVENT: begin
          if (phase_q != tms_pkg::PH_IDLE) begin
            if (nack) begin
              has_cmd    = 1'b1;
              cmd.two    = 1'b1;
              cmd.act0   = tms_pkg::ACT_STOP;
              cmd.act1   = tms_pkg::ACT_DONE;
              cmd.status = data_nack ? tms_pkg::ST_DATA_NACK : tms_pkg::ST_ADDR_NACK;
              cmd.count  = (phase_q == tms_pkg::PH_WRITE) ? 16'd0 : rx_pos_q;
              if (phase_q == tms_pkg::PH_WRITE) rx_pos_d = '0;
              phase_d    = tms_pkg::PH_IDLE;
              en_d       = '0;
              tx_pos_d   = '0;
            end else begin
              if (rxrdy && phase_q == tms_pkg::PH_READ) begin
                if (rx_pos_q < rx_count_q) begin
                  has_cmd  = 1'b1;
                  cmd.act0 = tms_pkg::ACT_RECV;
                  cmd.data = data_byte_i;
                  rx_pos_d = rx_next[15:0];
                  if (rx_next + 17'd1 == {1'b0, rx_count_q}) begin
                    cmd.two  = 1'b1;
                    cmd.act1 = tms_pkg::ACT_STOP;
                  end else if (rx_next == {1'b0, rx_count_q}) begin
                    en_d[tms_pkg::EN_RXRDY]  = 1'b0;
                    en_d[tms_pkg::EN_TXCOMP] = 1'b1;
                  end
                end
              end else if (txrdy && phase_q == tms_pkg::PH_WRITE) begin
                tx_pos_d = pos_next;
                if (sending) begin
                  has_cmd  = 1'b1;
                  cmd.act0 = tms_pkg::ACT_SEND;
                  cmd.data = rd_q;
                  if (pos_next >= tx_count_q) begin
                    cmd.two  = 1'b1;
                    cmd.act1 = tms_pkg::ACT_STOP;
                  end
                end else if (pos_next >= tx_count_q) begin
                  has_cmd  = 1'b1;
                  cmd.act0 = tms_pkg::ACT_STOP;
                end
                if (pos_next >= tx_count_q) begin
                  en_d[tms_pkg::EN_TXRDY]  = 1'b0;
                  en_d[tms_pkg::EN_TXCOMP] = 1'b1;
                end
              end
              if (txcomp) begin
                has_cmd = 1'b1;
                if (phase_q == tms_pkg::PH_WRITE && rx_count_q != 16'd0) begin
                  // Turn the bus around for the read phase, no internal address
                  rx_pos_d   = '0;
                  phase_d    = tms_pkg::PH_READ;
                  tx_pos_d   = '0;
                  cmd.act0   = (rx_count_q == 16'd1) ? tms_pkg::ACT_START_STOP
                                                     : tms_pkg::ACT_START;
                  cmd.target = slave_q;
                  cmd.dir    = 1'b1;
                  en_d       = 4'd0;
                  en_d[tms_pkg::EN_NACK]  = 1'b1;
                  en_d[tms_pkg::EN_RXRDY] = 1'b1;
                end else begin
                  if (phase_q == tms_pkg::PH_WRITE) rx_pos_d = '0;
                  cmd.act0   = tms_pkg::ACT_DONE;
                  cmd.status = tms_pkg::ST_OK;
                  cmd.count  = (phase_q == tms_pkg::PH_WRITE) ? 16'd0 : rx_pos_q;
                  phase_d    = tms_pkg::PH_IDLE;
                  en_d       = '0;
                  tx_pos_d   = '0;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Buffer read follows the next transmit position so the next byte to send is always ready
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= data_byte_i;
    if (mem_we && mem_waddr == mem_raddr) rd_q <= data_byte_i;
    else                                  rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tms_pkg::PH_IDLE;
      fill_q     <= '0;
      tx_count_q <= '0;
      tx_pos_q   <= '0;
      rx_count_q <= '0;
      rx_pos_q   <= '0;
      slave_q    <= '0;
      raddr_q    <= '0;
      rlen_q     <= '0;
      en_q       <= '0;
    end else begin
      phase_q    <= phase_d;
      fill_q     <= fill_d;
      tx_count_q <= tx_count_d;
      tx_pos_q   <= tx_pos_d;
      rx_count_q <= rx_count_d;
      rx_pos_q   <= rx_pos_d;
      slave_q    <= slave_d;
      raddr_q    <= raddr_d;
      rlen_q     <= rlen_d;
      en_q       <= en_d;
    end
  end

  assign push_o = accept && has_cmd;
  assign cmd_o  = cmd;

endmodule

FILE: rtl/tms_cmd_fifo.sv
module tms_cmd_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  tms_pkg::cmd_t push_cmd_i,
  input  logic          pop_i,
  output logic          full_o,
  output logic          empty_o,
  output tms_pkg::cmd_t head_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  tms_pkg::cmd_t    entry_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CNT_W'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) entry_q[wr_ptr_q] <= push_cmd_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop)      cnt_q <= cnt_q + CNT_W'(1);
      else if (do_pop && !do_push) cnt_q <= cnt_q - CNT_W'(1);
    end
  end

endmodule

FILE: rtl/tms_back.sv
module tms_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  tms_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [2:0]    action_o,
  output logic [7:0]    byte_out_o,
  output logic [6:0]    target_addr_o,
  output logic          read_dir_o,
  output logic [23:0]   reg_addr_o,
  output logic [1:0]    reg_addr_len_o,
  output logic [1:0]    status_o,
  output logic [15:0]   received_count_o,
  output logic          last_o
);

  logic        valid_q;
  logic        slot_q;
  logic        load;
  logic        final_slot;
  logic [2:0]  act;
  logic        is_byte, is_start, is_done;

  logic [2:0]  action_q;
  logic [7:0]  byte_q;
  logic [6:0]  target_q;
  logic        dir_q;
  logic [23:0] raddr_q;
  logic [1:0]  rlen_q;
  logic [1:0]  status_q;
  logic [15:0] count_q;
  logic        last_q;

  assign load       = !empty_i && (!valid_q || !out_stall_i);
  assign final_slot = slot_q || !head_i.two;
  assign pop_o      = load && final_slot;
  assign act        = slot_q ? head_i.act1 : head_i.act0;
  assign is_byte    = (act == tms_pkg::ACT_SEND) || (act == tms_pkg::ACT_RECV);
  assign is_start   = (act == tms_pkg::ACT_START) || (act == tms_pkg::ACT_START_STOP);
  assign is_done    = (act == tms_pkg::ACT_DONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= 1'b0;
    end else begin
      if (load)             valid_q <= 1'b1;
      else if (!out_stall_i) valid_q <= 1'b0;
      if (load) slot_q <= !final_slot;
    end
  end

  // Drop fields that mean nothing for the selected action
  always_ff @(posedge clk_i) begin
    if (load) begin
      action_q <= act;
      byte_q   <= is_byte  ? head_i.data   : 8'd0;
      target_q <= is_start ? head_i.target : 7'd0;
      dir_q    <= is_start ? head_i.dir    : 1'b0;
      raddr_q  <= is_start ? head_i.raddr  : 24'd0;
      rlen_q   <= is_start ? head_i.rlen   : 2'd0;
      status_q <= is_done  ? head_i.status : 2'd0;
      count_q  <= is_done  ? head_i.count  : 16'd0;
      last_q   <= final_slot;
    end
  end

  assign out_valid_o      = valid_q;
  assign action_o         = action_q;
  assign byte_out_o       = byte_q;
  assign target_addr_o    = target_q;
  assign read_dir_o       = dir_q;
  assign reg_addr_o       = raddr_q;
  assign reg_addr_len_o   = rlen_q;
  assign status_o         = status_q;
  assign received_count_o = count_q;
  assign last_o           = last_q;

endmodule

FILE: rtl/twi_master_transfer_sequencer.sv
// Channel  | Direction | Handshake               | Payload
// ---------+-----------+-------------------------+-------------------------------------
// in       | input     | in_valid_i / in_stall_o | op, addresses, lengths, byte, flags
// out      | output    | out_valid_o / out_stall_i | action, byte, start fields, done
//
// An item is taken when in_valid_i is high and in_stall_o low; each transaction can
// follow in the next cycle. The front decodes an item, updates the sequencing state
// and queues at most one command; the back turns each command into one or two result
// transactions at one per cycle while out_stall_i is low, so the output port bounds
// sustained throughput. A result passes through the command queue, then the back's
// output register. in_stall_o rises only when the command queue is full. Reset clears
// all control state; the transmit buffer contents are undefined until written.
module twi_master_transfer_sequencer #(
  parameter int unsigned TX_DEPTH  = 64,
  parameter int unsigned CMD_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  op_i,
  input  logic [6:0]  slave_addr_i,
  input  logic [6:0]  tx_len_i,
  input  logic [15:0] rx_len_i,
  input  logic [23:0] internal_addr_i,
  input  logic [1:0]  internal_addr_len_i,
  input  logic [7:0]  data_byte_i,
  input  logic        ev_nack_i,
  input  logic        ev_rxrdy_i,
  input  logic        ev_txrdy_i,
  input  logic        ev_txcomp_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  action_o,
  output logic [7:0]  byte_out_o,
  output logic [6:0]  target_addr_o,
  output logic        read_dir_o,
  output logic [23:0] reg_addr_o,
  output logic [1:0]  reg_addr_len_o,
  output logic [1:0]  status_o,
  output logic [15:0] received_count_o,
  output logic        last_o
);

  logic          push;
  logic          pop;
  logic          full;
  logic          empty;
  tms_pkg::cmd_t push_cmd;
  tms_pkg::cmd_t head_cmd;

  // Hold the input side only while the command queue has no free slot
  assign in_stall_o = full;

  // Front: buffer transmit bytes, track the phase, classify bus events
  tms_front #(
    .TX_DEPTH (TX_DEPTH)
  ) u_front (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .in_valid_i          (in_valid_i),
    .q_full_i            (full),
    .op_i                (op_i),
    .slave_addr_i        (slave_addr_i),
    .tx_len_i            (tx_len_i),
    .rx_len_i            (rx_len_i),
    .internal_addr_i     (internal_addr_i),
    .internal_addr_len_i (internal_addr_len_i),
    .data_byte_i         (data_byte_i),
    .ev_nack_i           (ev_nack_i),
    .ev_rxrdy_i          (ev_rxrdy_i),
    .ev_txrdy_i          (ev_txrdy_i),
    .ev_txcomp_i         (ev_txcomp_i),
    .push_o              (push),
    .cmd_o               (push_cmd)
  );

  // Decouple the front from output back-pressure
  tms_cmd_fifo #(
    .DEPTH (CMD_DEPTH)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_cmd_i (push_cmd),
    .pop_i      (pop),
    .full_o     (full),
    .empty_o    (empty),
    .head_o     (head_cmd)
  );

  // Back: expand each command into result transactions through an output register
  tms_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .empty_i          (empty),
    .head_i           (head_cmd),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .action_o         (action_o),
    .byte_out_o       (byte_out_o),
    .target_addr_o    (target_addr_o),
    .read_dir_o       (read_dir_o),
    .reg_addr_o       (reg_addr_o),
    .reg_addr_len_o   (reg_addr_len_o),
    .status_o         (status_o),
    .received_count_o (received_count_o),
    .last_o           (last_o)
  );

endmodule

FILE: tb/twi_master_transfer_sequencer_test.sv
`timescale 1ns / 1ps

module twi_master_transfer_sequencer_test;

  localparam int unsigned BUF_DEPTH   = 64;
  localparam int unsigned HOLD_CYCLES = 200;   // long receiver hold-off
  localparam int unsigned QUIET_LIMIT = 2000;  // cycles without any transaction
  localparam int unsigned TAIL_CYCLES = 20;    // settle time after the last result
  localparam logic [1:0]  OP_UNUSED   = 2'd3;  // undefined op, must be dropped

  // One input transaction, laid out field by field as on the ports.
  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  slave;
    logic [6:0]  tx_len;
    logic [15:0] rx_len;
    logic [23:0] iaddr;
    logic [1:0]  ialen;
    logic [7:0]  data;
    logic        nack;
    logic        rxrdy;
    logic        txrdy;
    logic        txcomp;
  } in_item_t;

  // One bus command as it leaves the output channel.
  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  byte_val;
    logic [6:0]  target;
    logic        dir;
    logic [23:0] raddr;
    logic [1:0]  rlen;
    logic [1:0]  status;
    logic [15:0] count;
    logic        last;
  } bus_cmd_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_item_t    drive_item;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  action;
  logic [7:0]  byte_out;
  logic [6:0]  target_addr;
  logic        read_dir;
  logic [23:0] reg_addr;
  logic [1:0]  reg_addr_len;
  logic [1:0]  status;
  logic [15:0] received_count;
  logic        last;

  twi_master_transfer_sequencer i_dut (
    .clk_i               (clk),
    .rst_ni              (rst_n),
    .in_valid_i          (in_valid),
    .in_stall_o          (in_stall),
    .op_i                (drive_item.op),
    .slave_addr_i        (drive_item.slave),
    .tx_len_i            (drive_item.tx_len),
    .rx_len_i            (drive_item.rx_len),
    .internal_addr_i     (drive_item.iaddr),
    .internal_addr_len_i (drive_item.ialen),
    .data_byte_i         (drive_item.data),
    .ev_nack_i           (drive_item.nack),
    .ev_rxrdy_i          (drive_item.rxrdy),
    .ev_txrdy_i          (drive_item.txrdy),
    .ev_txcomp_i         (drive_item.txcomp),
    .out_valid_o         (out_valid),
    .out_stall_i         (out_stall),
    .action_o            (action),
    .byte_out_o          (byte_out),
    .target_addr_o       (target_addr),
    .read_dir_o          (read_dir),
    .reg_addr_o          (reg_addr),
    .reg_addr_len_o      (reg_addr_len),
    .status_o            (status),
    .received_count_o    (received_count),
    .last_o              (last)
  );

  // Sequencer state as the testbench tracks it, updated at each accepted input.
  logic [1:0]  seq_phase;
  logic [7:0]  tx_buf [BUF_DEPTH];
  int unsigned fill_cnt;
  int unsigned tx_total;
  int unsigned tx_idx;
  int unsigned rx_total;
  int unsigned rx_idx;
  logic [6:0]  held_slave;
  logic [23:0] held_raddr;
  logic [1:0]  held_rlen;
  logic [3:0]  ev_enable;

  bus_cmd_t    step_cmds[$];     // commands caused by the current input
  bus_cmd_t    pending_cmds[$];  // commands still owed by the block, oldest first

  // Knobs and tallies shared by the stimulus, receiver and monitor.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req;
  int unsigned hold_ack;
  int unsigned items_sent;
  int unsigned items_acted;
  int unsigned results_checked;
  int unsigned check_failures;
  int unsigned done_tally [4];
  int unsigned quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic bus_cmd_t mk_cmd(logic [2:0] act, logic [7:0] b, logic [6:0] tgt,
                                      logic dir, logic [23:0] ra, logic [1:0] rl,
                                      logic [1:0] st, logic [15:0] cnt);
    bus_cmd_t c;
    c = '{act, b, tgt, dir, ra, rl, st, cnt, 1'b0};
    return c;
  endfunction

  // End the transaction: report status and bytes read, drop back to idle.
  function automatic void close_transfer(logic [1:0] st);
    step_cmds.push_back(mk_cmd(tms_pkg::ACT_DONE, 8'd0, 7'd0, 1'b0, 24'd0, 2'd0, st,
                               16'(rx_idx)));
    seq_phase = tms_pkg::PH_IDLE;
    ev_enable = '0;
  endfunction

  // Open the read phase; only a transaction with no write phase carries the
  // internal address on this start.
  function automatic void open_read(logic with_addr);
    rx_idx    = 0;
    seq_phase = tms_pkg::PH_READ;
    ev_enable = '0;
    ev_enable[tms_pkg::EN_NACK]  = 1'b1;
    ev_enable[tms_pkg::EN_RXRDY] = 1'b1;
    step_cmds.push_back(mk_cmd(rx_total == 1 ? tms_pkg::ACT_START_STOP : tms_pkg::ACT_START,
                               8'd0, held_slave, 1'b1, with_addr ? held_raddr : 24'd0,
                               with_addr ? held_rlen : 2'd0, tms_pkg::ST_OK, 16'd0));
  endfunction

  // Apply one accepted input to the tracked state and queue the commands it
  // owes. Returns whether the block acts on it at all.
  function automatic bit advance_sequencer(in_item_t it);
    logic [3:0]  en;
    logic        nk;
    logic        rr;
    logic        tr;
    logic        tc;
    logic        data_nack;
    bit          stored;
    int unsigned avail;
    stored = 1'b0;
    step_cmds.delete();
    case (it.op)
      tms_pkg::OP_APPEND: begin
        // Bytes are buffered only between transactions and up to the depth.
        if (seq_phase == tms_pkg::PH_IDLE && fill_cnt < BUF_DEPTH) begin
          tx_buf[fill_cnt] = it.data;
          fill_cnt++;
          stored = 1'b1;
        end
      end
      tms_pkg::OP_BEGIN: begin
        if (seq_phase != tms_pkg::PH_IDLE) begin
          // Refuse the request; the running transaction carries on.
          step_cmds.push_back(mk_cmd(tms_pkg::ACT_DONE, 8'd0, 7'd0, 1'b0, 24'd0, 2'd0,
                                     tms_pkg::ST_BAD_REQ, 16'd0));
        end else begin
          avail    = fill_cnt;
          fill_cnt = 0;
          if ((it.tx_len == 0 && it.rx_len == 0) || it.tx_len > avail) begin
            rx_idx = 0;
            close_transfer(tms_pkg::ST_BAD_REQ);
          end else begin
            held_slave = it.slave;
            held_rlen  = it.ialen;
            held_raddr = (it.ialen != 0) ? it.iaddr : 24'd0;
            tx_total   = it.tx_len;
            rx_total   = it.rx_len;
            tx_idx     = 0;
            rx_idx     = 0;
            if (tx_total > 0) begin
              // Preload the first byte, then start the write phase.
              seq_phase = tms_pkg::PH_WRITE;
              step_cmds.push_back(mk_cmd(tms_pkg::ACT_SEND, tx_buf[0], 7'd0, 1'b0, 24'd0,
                                         2'd0, tms_pkg::ST_OK, 16'd0));
              tx_idx = 1;
              step_cmds.push_back(mk_cmd(tx_total == 1 ? tms_pkg::ACT_START_STOP
                                                       : tms_pkg::ACT_START,
                                         8'd0, held_slave, 1'b0, held_raddr, held_rlen,
                                         tms_pkg::ST_OK, 16'd0));
              ev_enable = '0;
              ev_enable[tms_pkg::EN_NACK] = 1'b1;
              ev_enable[tx_total == 1 ? tms_pkg::EN_TXCOMP : tms_pkg::EN_TXRDY] = 1'b1;
            end else begin
              open_read(1'b1);
            end
          end
        end
      end
      tms_pkg::OP_EVENT: begin
        if (seq_phase != tms_pkg::PH_IDLE) begin
          // Mask with the enables as they stood when the event came in.
          en = ev_enable;
          nk = it.nack   & en[tms_pkg::EN_NACK];
          rr = it.rxrdy  & en[tms_pkg::EN_RXRDY];
          tr = it.txrdy  & en[tms_pkg::EN_TXRDY];
          tc = it.txcomp & en[tms_pkg::EN_TXCOMP];
          if (nk) begin
            data_nack = (seq_phase == tms_pkg::PH_WRITE) ? (tx_idx > 1) : (rx_idx > 0);
            step_cmds.push_back(mk_cmd(tms_pkg::ACT_STOP, 8'd0, 7'd0, 1'b0, 24'd0, 2'd0,
                                       tms_pkg::ST_OK, 16'd0));
            if (seq_phase == tms_pkg::PH_WRITE) rx_idx = 0;
            close_transfer(data_nack ? tms_pkg::ST_DATA_NACK : tms_pkg::ST_ADDR_NACK);
          end else begin
            if (rr && seq_phase == tms_pkg::PH_READ) begin
              if (rx_idx < rx_total) begin
                step_cmds.push_back(mk_cmd(tms_pkg::ACT_RECV, it.data, 7'd0, 1'b0, 24'd0,
                                           2'd0, tms_pkg::ST_OK, 16'd0));
                rx_idx++;
                if (rx_idx + 1 == rx_total) begin
                  step_cmds.push_back(mk_cmd(tms_pkg::ACT_STOP, 8'd0, 7'd0, 1'b0, 24'd0,
                                             2'd0, tms_pkg::ST_OK, 16'd0));
                end else if (rx_idx == rx_total) begin
                  ev_enable[tms_pkg::EN_RXRDY]  = 1'b0;
                  ev_enable[tms_pkg::EN_TXCOMP] = 1'b1;
                end
              end
            end else if (tr && seq_phase == tms_pkg::PH_WRITE) begin
              if (tx_idx < tx_total && tx_idx < BUF_DEPTH) begin
                step_cmds.push_back(mk_cmd(tms_pkg::ACT_SEND, tx_buf[tx_idx], 7'd0, 1'b0,
                                           24'd0, 2'd0, tms_pkg::ST_OK, 16'd0));
                tx_idx++;
              end
              if (tx_idx >= tx_total) begin
                step_cmds.push_back(mk_cmd(tms_pkg::ACT_STOP, 8'd0, 7'd0, 1'b0, 24'd0,
                                           2'd0, tms_pkg::ST_OK, 16'd0));
                ev_enable[tms_pkg::EN_TXRDY]  = 1'b0;
                ev_enable[tms_pkg::EN_TXCOMP] = 1'b1;
              end
            end
            if (tc) begin
              if (seq_phase == tms_pkg::PH_WRITE && rx_total > 0) begin
                open_read(1'b0);
              end else begin
                if (seq_phase == tms_pkg::PH_WRITE) rx_idx = 0;
                close_transfer(tms_pkg::ST_OK);
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (step_cmds.size() != 0) step_cmds[step_cmds.size() - 1].last = 1'b1;
    foreach (step_cmds[i]) pending_cmds.push_back(step_cmds[i]);
    return stored || (step_cmds.size() != 0);
  endfunction

  // ---------------------------------------------------------------------------
  // Input construction and driving
  // ---------------------------------------------------------------------------

  // Every field random; the helpers below override what matters.
  function automatic in_item_t rand_item();
    in_item_t it;
    it.op     = 2'($urandom_range(0, 3));
    it.slave  = 7'($urandom);
    it.tx_len = 7'($urandom);
    it.rx_len = 16'($urandom);
    it.iaddr  = 24'($urandom);
    it.ialen  = 2'($urandom);
    it.data   = 8'($urandom);
    it.nack   = 1'($urandom);
    it.rxrdy  = 1'($urandom);
    it.txrdy  = 1'($urandom);
    it.txcomp = 1'($urandom);
    return it;
  endfunction

  function automatic in_item_t mk_append(logic [7:0] d);
    in_item_t it;
    it      = rand_item();
    it.op   = tms_pkg::OP_APPEND;
    it.data = d;
    return it;
  endfunction

  function automatic in_item_t mk_begin(logic [6:0] sa, logic [6:0] tl, logic [15:0] rl,
                                        logic [23:0] ia, logic [1:0] ial);
    in_item_t it;
    it        = rand_item();
    it.op     = tms_pkg::OP_BEGIN;
    it.slave  = sa;
    it.tx_len = tl;
    it.rx_len = rl;
    it.iaddr  = ia;
    it.ialen  = ial;
    return it;
  endfunction

  function automatic in_item_t mk_event(logic n, logic r, logic t, logic c, logic [7:0] d);
    in_item_t it;
    it        = rand_item();
    it.op     = tms_pkg::OP_EVENT;
    it.nack   = n;
    it.rxrdy  = r;
    it.txrdy  = t;
    it.txcomp = c;
    it.data   = d;
    return it;
  endfunction

  // Offer one transaction, with a random gap ahead of it, and hold it until
  // the block takes it. Valid stays high afterwards so back-to-back items
  // never drop it; whoever waits next lowers it.
  task automatic push_item(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    drive_item <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (advance_sequencer(it)) items_acted++;
  endtask

  // Stop offering and wait until every owed command has come out.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_cmds.size() != 0) @(posedge clk);
  endtask

  // Answer the running transaction with the bus events it is waiting for,
  // mixed with masked flags and stray items; abort with a NACK now and then,
  // and always once abort_after events have passed.
  task automatic step_transfer_events(input int unsigned abort_after,
                                      input int unsigned nack_odds);
    int unsigned steps;
    in_item_t    it;
    steps = 0;
    while (seq_phase != tms_pkg::PH_IDLE) begin
      steps++;
      it = mk_event(1'b0, 1'($urandom), 1'($urandom), 1'($urandom), 8'($urandom));
      if (steps > abort_after || (nack_odds != 0 && $urandom_range(1, nack_odds) == 1)) begin
        it.nack = 1'b1;
      end else if ($urandom_range(0, 11) == 0) begin
        // Stray item mid-transaction: dropped append, refused begin, or nothing.
        it = rand_item();
        if (it.op == tms_pkg::OP_EVENT) {it.nack, it.rxrdy, it.txrdy, it.txcomp} = 4'b0;
      end else if (ev_enable[tms_pkg::EN_TXCOMP]) begin
        it.txcomp = 1'b1;
      end else if (seq_phase == tms_pkg::PH_WRITE) begin
        it.txrdy = 1'b1;
      end else begin
        it.rxrdy = 1'b1;
      end
      push_item(it);
    end
  endtask

  // One buffer fill, begin and event sequence with random shape and content.
  task automatic run_random_transfer();
    int unsigned tl;
    int unsigned rl;
    int unsigned n_app;
    in_item_t    it;
    case ($urandom_range(0, 19))
      0:          tl = $urandom_range(BUF_DEPTH + 1, 127);
      1, 2, 3, 4: tl = 0;
      default:    tl = $urandom_range(1, 6);
    endcase
    case ($urandom_range(0, 9))
      0:       rl = $urandom_range(0, 65535);
      1, 2:    rl = 0;
      default: rl = $urandom_range(1, 4);
    endcase
    case ($urandom_range(0, 9))
      0:       n_app = tl + $urandom_range(1, 3);
      1:       n_app = (tl == 0) ? 0 : $urandom_range(0, tl - 1);
      default: n_app = tl;
    endcase
    if (n_app > BUF_DEPTH + 2) n_app = BUF_DEPTH + 2;
    repeat (n_app) begin
      if ($urandom_range(0, 7) == 0) begin
        // Idle-time noise: undefined op or an event nobody is waiting for.
        it    = rand_item();
        it.op = $urandom_range(0, 1) ? OP_UNUSED : tms_pkg::OP_EVENT;
        push_item(it);
      end
      push_item(mk_append(8'($urandom)));
    end
    push_item(mk_begin(7'($urandom), 7'(tl), 16'(rl), 24'($urandom), 2'($urandom)));
    step_transfer_events($urandom_range(3, 12), 30);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    in_item_t it;
    // Idle noise: event with every flag and an undefined op.
    push_item(mk_event(1'b1, 1'b1, 1'b1, 1'b1, 8'hFF));
    it    = rand_item();
    it.op = OP_UNUSED;
    push_item(it);
    // Bad requests: nothing to do, and more bytes than buffered.
    push_item(mk_begin(7'h7F, 7'd0, 16'd0, 24'hFFFFFF, 2'd3));
    push_item(mk_begin(7'h00, 7'd127, 16'hFFFF, 24'd0, 2'd0));
    // Two-byte write with a three-byte internal address.
    push_item(mk_append(8'h00));
    push_item(mk_append(8'hFF));
    push_item(mk_begin(7'h7F, 7'd2, 16'd0, 24'hFFFFFF, 2'd3));
    push_item(mk_begin(7'h00, 7'd1, 16'd1, 24'd0, 2'd0));      // refused while busy
    push_item(mk_append(8'hAA));                                 // dropped while busy
    push_item(mk_event(1'b0, 1'b1, 1'b1, 1'b0, 8'h55));        // RXRDY masked in write
    push_item(mk_event(1'b0, 1'b0, 1'b1, 1'b0, 8'h00));        // TXRDY masked after STOP
    push_item(mk_event(1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
    // Single byte each way: START+STOP in both phases, address dropped.
    push_item(mk_append(8'h5A));
    push_item(mk_begin(7'h00, 7'd1, 16'd1, 24'hABCDEF, 2'd0));
    push_item(mk_event(1'b0, 1'b1, 1'b0, 1'b1, 8'h11));
    push_item(mk_event(1'b0, 1'b1, 1'b0, 1'b0, 8'hFF));
    push_item(mk_event(1'b0, 1'b0, 1'b0, 1'b1, 8'h00));
    // Read-only transaction ended by an address NACK.
    push_item(mk_begin(7'h55, 7'd0, 16'd2, 24'h123456, 2'd2));
    push_item(mk_event(1'b1, 1'b0, 1'b0, 1'b0, 8'h00));
    // Write ended by a data NACK with every flag raised at once.
    push_item(mk_append(8'h01));
    push_item(mk_append(8'h80));
    push_item(mk_append(8'h7F));
    push_item(mk_begin(7'h2A, 7'd3, 16'd0, 24'h00A5A5, 2'd1));
    push_item(mk_event(1'b0, 1'b0, 1'b1, 1'b0, 8'h00));
    push_item(mk_event(1'b1, 1'b1, 1'b1, 1'b1, 8'h00));
    // Read ended by a NACK after one byte: data NACK.
    push_item(mk_begin(7'h01, 7'd0, 16'd3, 24'd0, 2'd0));
    push_item(mk_event(1'b0, 1'b1, 1'b0, 1'b0, 8'h80));
    push_item(mk_event(1'b1, 1'b1, 1'b0, 1'b0, 8'h7F));
    wait_drained();
  endtask

  task automatic test_random_transfers(input int unsigned n_items);
    int unsigned goal;
    goal = items_sent + n_items;
    while (items_sent < goal) run_random_transfer();
    wait_drained();
  endtask

  // Overfill the buffer, then start a write of all of it and cut it short
  // with a NACK after a few bytes.
  task automatic test_full_buffer();
    repeat (BUF_DEPTH + 1) push_item(mk_append(8'($urandom)));
    push_item(mk_begin(7'($urandom), 7'(BUF_DEPTH), 16'd1, 24'($urandom), 2'($urandom)));
    step_transfer_events(6, 0);
    wait_drained();
  endtask

  // Hold the output off for a long stretch while refused begins pile up, so
  // the command queue fills and the input stalls.
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_req++;
    push_item(mk_append(8'($urandom)));
    push_item(mk_begin(7'($urandom), 7'd1, 16'd0, 24'($urandom), 2'($urandom)));
    repeat (12) push_item(mk_begin(7'($urandom), 7'd1, 16'd1, 24'($urandom), 2'($urandom)));
    push_item(mk_event(1'b0, 1'b0, 1'b0, 1'b1, 8'($urandom)));
    wait_drained();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall, or a long counted hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int unsigned held;
    out_stall = 1'b0;
    held      = 0;
    forever begin
      @(posedge clk);
      if (held > 0) begin
        held--;
        out_stall <= 1'b1;
      end else if (hold_req != hold_ack) begin
        hold_ack  = hold_req;
        held      = HOLD_CYCLES - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result monitor: compare each accepted command with the oldest owed one.
  // ---------------------------------------------------------------------------
  function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      check_failures++;
    end
  endfunction

  always @(posedge clk) begin : result_monitor
    bus_cmd_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_cmds.size() == 0) begin
        $error("unexpected result: action %0d byte %0d status %0d", action, byte_out, status);
        check_failures++;
      end else begin
        want = pending_cmds.pop_front();
        compare_field("action", 32'(want.action), 32'(action));
        compare_field("byte_out", 32'(want.byte_val), 32'(byte_out));
        compare_field("target_addr", 32'(want.target), 32'(target_addr));
        compare_field("read_dir", 32'(want.dir), 32'(read_dir));
        compare_field("reg_addr", 32'(want.raddr), 32'(reg_addr));
        compare_field("reg_addr_len", 32'(want.rlen), 32'(reg_addr_len));
        compare_field("status", 32'(want.status), 32'(status));
        compare_field("received_count", 32'(want.count), 32'(received_count));
        compare_field("last", 32'(want.last), 32'(last));
        results_checked++;
        if (want.action == tms_pkg::ACT_DONE) done_tally[want.status]++;
      end
    end
  end

  // Watchdog: end the run if neither channel moves for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("twi_master_transfer_sequencer regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    drive_item      = '0;
    seq_phase       = tms_pkg::PH_IDLE;
    fill_cnt        = 0;
    tx_total        = 0;
    tx_idx          = 0;
    rx_total        = 0;
    rx_idx          = 0;
    held_slave      = '0;
    held_raddr      = '0;
    held_rlen       = '0;
    ev_enable       = '0;
    hold_req        = 0;
    hold_ack        = 0;
    items_sent      = 0;
    items_acted     = 0;
    results_checked = 0;
    check_failures  = 0;
    quiet_cycles    = 0;
    foreach (done_tally[i]) done_tally[i] = 0;
    // Sender idles more lightly than the receiver first.
    send_idle_pct   = 30;
    recv_idle_pct   = 77;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_transfers(10);
    test_backpressure();

    // Swap: a slow sender against an eager receiver.
    send_idle_pct = 77;
    recv_idle_pct = 30;
    test_full_buffer();
    test_random_transfers(10);

    // Full rate on both sides.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_transfers(10);

    // Let any stray result show up before judging.
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d input transactions (%0d acted on), %0d commands checked",
             items_sent, items_acted, results_checked);
    $display("transfers closed: %0d ok, %0d address nack, %0d data nack, %0d refused",
             done_tally[tms_pkg::ST_OK], done_tally[tms_pkg::ST_ADDR_NACK],
             done_tally[tms_pkg::ST_DATA_NACK], done_tally[tms_pkg::ST_BAD_REQ]);
    if (check_failures == 0 && pending_cmds.size() == 0) begin
      $display("twi_master_transfer_sequencer regression: pass");
    end else begin
      $display("twi_master_transfer_sequencer regression: fail");
    end
    $finish;
  end

endmodule

FILE: twi_master_transfer_sequencer.f
rtl/tms_pkg.sv
rtl/tms_front.sv
rtl/tms_cmd_fifo.sv
rtl/tms_back.sv
rtl/twi_master_transfer_sequencer.sv
tb/twi_master_transfer_sequencer_test.sv
